// ----- sv/spmf_pkg.sv -----
// shared types and constants of the strict priority multi fifo
package spmf_pkg;

   localparam int LEVELS_DEF      = 8;
   localparam int LEVEL_DEPTH_DEF = 16;
   localparam int MAX_WANT_DEF    = 16;

   localparam int MAX_LVL_W = 5;
   localparam int OP_W      = 2;
   localparam int VALUE_W   = 32;
   localparam int PRI_W     = 3;
   localparam int WANT_W    = 5;
   localparam int STATUS_W  = 2;
   localparam int CNT_W     = 5;
   localparam int CSR_W     = 4;

   localparam logic [CSR_W-1:0] LEVELS_RESET = 4'd8;

   typedef enum logic [OP_W-1:0] {
      OP_PUT      = 2'd0,
      OP_GET      = 2'd1,
      OP_GET_MANY = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic                 push;
      logic [MAX_LVL_W-1:0] push_level;
      logic                 pop;
      logic [MAX_LVL_W-1:0] pop_level;
   } lvl_cmd_type;

endpackage

// ----- sv/spmf_ram.sv -----
// generic single write port ram with registered read
module spmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/spmf_levels.sv -----
// per level head, tail and fill count registers
module spmf_levels
   import spmf_pkg::*;
#(
   parameter int LEVELS      = LEVELS_DEF,
   parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1,
   localparam int PTR_W  = $clog2(LEVEL_DEPTH),
   localparam int CNT_LW = $clog2(LEVEL_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  lvl_cmd_type       cmd,
   input  logic [LVL_W-1:0]  rd_level,
   output logic [CNT_LW-1:0] rd_count,
   output logic [PTR_W-1:0]  tail_ptr,
   output logic [PTR_W-1:0]  head_ptr,
   output logic [LEVELS-1:0] nonempty
);

   logic [PTR_W-1:0]  head_ff  [LEVELS];
   logic [PTR_W-1:0]  head_in  [LEVELS];
   logic [PTR_W-1:0]  tail_ff  [LEVELS];
   logic [PTR_W-1:0]  tail_in  [LEVELS];
   logic [CNT_LW-1:0] count_ff [LEVELS];
   logic [CNT_LW-1:0] count_in [LEVELS];
   logic [LVL_W-1:0]  push_idx;
   logic [LVL_W-1:0]  pop_idx;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(LEVEL_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + 1'b1;
      end
      return res;
   endfunction

   assign push_idx = LVL_W'(cmd.push_level);
   assign pop_idx  = LVL_W'(cmd.pop_level);
   assign rd_count = count_ff[rd_level];
   assign tail_ptr = tail_ff[push_idx];
   assign head_ptr = head_ff[pop_idx];

   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         nonempty[i] = (count_ff[i] != '0);
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.push) begin
         tail_in[push_idx]  = wrap_inc(tail_ff[push_idx]);
         count_in[push_idx] = count_ff[push_idx] + 1'b1;
      end
      if (cmd.pop) begin
         head_in[pop_idx]  = wrap_inc(head_ff[pop_idx]);
         count_in[pop_idx] = count_ff[pop_idx] - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- sv/strict_priority_multi_fifo_unit.sv -----
// top level: strict priority multi level queue with item sequencer
//
// usage
// - req channel (valid/ready) takes one item: operation, value, priority_req, want
// - rsp channel (valid/ready) gives one or more results per item, none for op_none
// - csr_wr_en with csr_wr_data writes the level count; write only while idle
// - put: the item is taken, then checked and stored in the put state; its single
//   result is loaded from idle once the result register is free
// - get: the get state finds the level, then the pop state reads the entry
//   memory and the wait state loads the result
// - get_many: the sum state adds up the fill counts one active level at a time,
//   then each popped value goes through the pop and wait states in turn
// - the block takes one item at a time; req_ready is high only when idle
// - a stalled rsp channel holds the result register; the sequencer waits
// - reset empties every level and sets the level count to eight; the entry
//   memory itself is not cleared
module strict_priority_multi_fifo_unit
   import spmf_pkg::*;
#(
   parameter int LEVELS      = LEVELS_DEF,
   parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
   parameter int MAX_WANT    = MAX_WANT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [PRI_W-1:0]    req_priority_req,
   input  logic [WANT_W-1:0]   req_want,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_out_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last,
   output logic [CNT_W-1:0]    rsp_returned_count,
   input  logic                csr_wr_en,
   input  logic [CSR_W-1:0]    csr_wr_data
);

   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W  = $clog2(LEVEL_DEPTH);
   localparam int CNT_LW = $clog2(LEVEL_DEPTH + 1);
   localparam int ACT_W  = $clog2(LEVELS + 1);
   localparam int SUM_W  = $clog2(LEVELS * LEVEL_DEPTH + 1);
   localparam int ADDR_W = LVL_W + PTR_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PUT   = 6'b000010,
      S_GET   = 6'b000100,
      S_SUM   = 6'b001000,
      S_POP   = 6'b010000,
      S_WAIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CSR_W-1:0]   csr_levels_ff;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [PRI_W-1:0]   pri_ff, pri_in;
   logic [WANT_W-1:0]  want_ff, want_in;
   logic [LVL_W-1:0]   idx_ff, idx_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   total_n_ff, total_n_in;
   logic [CNT_W-1:0]   remaining_ff, remaining_in;
   status_type         reply_status_ff, reply_status_in;
   logic               reply_ff, reply_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic               rsp_load;
   logic               slot_free;

   logic [ACT_W-1:0]   act_levels;
   logic [LEVELS-1:0]  active_mask;
   logic [LEVELS-1:0]  avail_mask;
   logic               found;
   logic [LVL_W-1:0]   sel;

   lvl_cmd_type        cmd;
   logic [LVL_W-1:0]   rd_level;
   logic [CNT_LW-1:0]  rd_count;
   logic [PTR_W-1:0]   tail_ptr;
   logic [PTR_W-1:0]   head_ptr;
   logic [LEVELS-1:0]  nonempty;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [VALUE_W-1:0] ram_rd_data;

   logic [SUM_W-1:0]   acc_sum;
   logic [WANT_W-1:0]  want_sat;
   logic [LVL_W-1:0]   pri_idx;

   // active level count, clamped to one .. LEVELS
   always_comb begin
      if (csr_levels_ff == '0) begin
         act_levels = ACT_W'(1);
      end else if (int'(csr_levels_ff) > LEVELS) begin
         act_levels = ACT_W'(LEVELS);
      end else begin
         act_levels = ACT_W'(csr_levels_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         active_mask[i] = (i < int'(act_levels));
      end
   end

   assign avail_mask = nonempty & active_mask;
   assign found      = |avail_mask;

   // lowest set bit is the highest priority level
   always_comb begin
      sel = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (avail_mask[i]) begin
            sel = LVL_W'(i);
         end
      end
   end

   assign pri_idx   = LVL_W'(pri_ff);
   assign rd_level  = (state_ff == S_SUM) ? idx_ff : pri_idx;
   assign acc_sum   = acc_ff + SUM_W'(rd_count);
   assign want_sat  = (int'(want_ff) > MAX_WANT) ? WANT_W'(MAX_WANT) : want_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   spmf_levels #(
      .LEVELS      (LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_levels (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_level (rd_level),
      .rd_count (rd_count),
      .tail_ptr (tail_ptr),
      .head_ptr (head_ptr),
      .nonempty (nonempty)
   );

   spmf_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (2 ** ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr ({pri_idx, tail_ptr}),
      .wr_data (value_ff),
      .rd_en   (ram_rd_en),
      .rd_addr ({sel, head_ptr}),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE) && !reply_ff;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      value_in        = value_ff;
      pri_in          = pri_ff;
      want_in         = want_ff;
      idx_in          = idx_ff;
      acc_in          = acc_ff;
      total_n_in      = total_n_ff;
      remaining_in    = remaining_ff;
      reply_status_in = reply_status_ff;
      reply_in        = reply_ff;
      cmd             = '0;
      cmd.push_level  = MAX_LVL_W'(pri_idx);
      cmd.pop_level   = MAX_LVL_W'(sel);
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      rsp_load        = 1'b0;
      rsp_value_in    = rsp_value_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_cnt_in      = rsp_cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (reply_ff) begin
               if (slot_free) begin
                  rsp_load      = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = reply_status_ff;
                  rsp_last_in   = 1'b1;
                  rsp_cnt_in    = '0;
                  reply_in      = 1'b0;
               end
            end else if (req_valid) begin
               value_in = req_value;
               pri_in   = req_priority_req;
               want_in  = req_want;
               idx_in   = '0;
               acc_in   = '0;
               unique case (op_type'(req_operation))
                  OP_PUT:      state_in = S_PUT;
                  OP_GET:      state_in = S_GET;
                  OP_GET_MANY: state_in = S_SUM;
                  OP_NONE:     state_in = S_IDLE;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_PUT: begin
            priority if (int'(pri_ff) >= int'(act_levels)) begin
               reply_status_in = STAT_RANGE;
            end else if (rd_count == CNT_LW'(LEVEL_DEPTH)) begin
               reply_status_in = STAT_FULL;
            end else begin
               reply_status_in = STAT_OK;
               ram_wr_en       = 1'b1;
               cmd.push        = 1'b1;
            end
            reply_in = 1'b1;
            state_in = S_IDLE;
         end
         S_GET: begin
            if (found) begin
               total_n_in   = CNT_W'(1);
               remaining_in = CNT_W'(1);
               state_in     = S_POP;
            end else begin
               reply_status_in = STAT_EMPTY;
               reply_in        = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_SUM: begin
            acc_in = acc_sum;
            idx_in = idx_ff + 1'b1;
            if (int'(idx_ff) == int'(act_levels) - 1) begin
               priority if (acc_sum == '0) begin
                  reply_status_in = STAT_EMPTY;
                  reply_in        = 1'b1;
                  state_in        = S_IDLE;
               end else if (want_sat == '0) begin
                  reply_status_in = STAT_OK;
                  reply_in        = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  if (int'(acc_sum) < int'(want_sat)) begin
                     total_n_in   = CNT_W'(acc_sum);
                     remaining_in = CNT_W'(acc_sum);
                  end else begin
                     total_n_in   = want_sat;
                     remaining_in = want_sat;
                  end
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            ram_rd_en = 1'b1;
            cmd.pop   = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_value_in  = ram_rd_data;
               rsp_status_in = STAT_OK;
               rsp_last_in   = (remaining_ff == CNT_W'(1));
               rsp_cnt_in    = total_n_ff;
               remaining_in  = remaining_ff - 1'b1;
               state_in      = (remaining_ff == CNT_W'(1)) ? S_IDLE : S_POP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         csr_levels_ff <= LEVELS_RESET;
         reply_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_levels_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff        <= value_in;
      pri_ff          <= pri_in;
      want_ff         <= want_in;
      idx_ff          <= idx_in;
      acc_ff          <= acc_in;
      total_n_ff      <= total_n_in;
      remaining_ff    <= remaining_in;
      reply_status_ff <= reply_status_in;
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_cnt_ff    <= rsp_cnt_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_value      = rsp_value_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_returned_count = rsp_cnt_ff;

   // a pop is only issued when some active level holds data
   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> found)
      else $error("pop issued with no data in active levels");

   // the last result of an item returns the sequencer to idle
   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == S_IDLE))
      else $error("last result did not end the item");

   // a result that is not the last is followed by the next pop
   a_more_pops: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !rsp_last_in) |=> (state_ff == S_POP))
      else $error("non-last result not followed by a pop");

   // memory read data holds while the result register is stalled
   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && !slot_free) |=> $stable(ram_rd_data))
      else $error("memory read data changed during stall");

endmodule

// ----- tb/sv/strict_priority_multi_fifo_unit_tb.sv -----
// testbench of the strict priority multi level queue with a result predictor
`timescale 1ns / 100ps

module strict_priority_multi_fifo_unit_tb
   import spmf_pkg::*;
();

   localparam int CLK_HALF         = 10;
   localparam int RESET_CYCLES     = 6;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int CYCLE_LIMIT      = 300000;

   typedef struct {
      logic [VALUE_W-1:0] out_value;
      status_type         status;
      logic               last;
      logic [CNT_W-1:0]   returned_count;
   } queue_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = '0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic [PRI_W-1:0]    req_priority_req = '0;
   logic [WANT_W-1:0]   req_want = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [VALUE_W-1:0]  rsp_out_value;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;
   logic [CNT_W-1:0]    rsp_returned_count;
   logic                csr_wr_en = 1'b0;
   logic [CSR_W-1:0]    csr_wr_data = '0;

   // predictor state
   logic [VALUE_W-1:0] level_words [LEVELS_DEF][LEVEL_DEPTH_DEF];
   int unsigned        level_head [LEVELS_DEF];
   int unsigned        level_tail [LEVELS_DEF];
   int unsigned        level_fill [LEVELS_DEF];
   logic [CSR_W-1:0]   levels_reg = LEVELS_RESET;

   queue_result_type expected_results[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          idle_on = 1'b1;
   logic        long_hold_pending = 1'b0;

   strict_priority_multi_fifo_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_value          (req_value),
      .req_priority_req   (req_priority_req),
      .req_want           (req_want),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_value      (rsp_out_value),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .rsp_returned_count (rsp_returned_count),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL strict_priority_multi_fifo_unit");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < LEVELS_DEF; i++) begin
         level_head[i] = 0;
         level_tail[i] = 0;
         level_fill[i] = 0;
      end
   end

   function automatic int unsigned active_levels();
      if (levels_reg == 0) return 1;
      if (levels_reg > LEVELS_DEF) return LEVELS_DEF;
      return 32'(levels_reg);
   endfunction

   function automatic int unsigned visible_words();
      int unsigned sum;
      sum = 0;
      for (int i = 0; i < active_levels(); i++) sum += level_fill[i];
      return sum;
   endfunction

   function automatic logic [VALUE_W-1:0] pop_top();
      logic [VALUE_W-1:0] word;
      word = '0;
      for (int i = 0; i < active_levels(); i++) begin
         if (level_fill[i] != 0) begin
            word = level_words[i][level_head[i]];
            level_head[i] = (level_head[i] + 1) % LEVEL_DEPTH_DEF;
            level_fill[i]--;
            return word;
         end
      end
      return word;
   endfunction

   function automatic void add_result(logic [VALUE_W-1:0] word, status_type st, logic last,
                                      int unsigned cnt);
      queue_result_type r;
      r.out_value      = word;
      r.status         = st;
      r.last           = last;
      r.returned_count = CNT_W'(cnt);
      expected_results.push_back(r);
   endfunction

   function automatic void predict_item(op_type op, logic [VALUE_W-1:0] word,
                                        logic [PRI_W-1:0] pri, logic [WANT_W-1:0] want);
      int unsigned avail;
      int unsigned limit;
      int unsigned n;
      case (op)
         OP_PUT: begin
            if (pri >= active_levels()) begin
               add_result('0, STAT_RANGE, 1'b1, 0);
            end else if (level_fill[pri] >= LEVEL_DEPTH_DEF) begin
               add_result('0, STAT_FULL, 1'b1, 0);
            end else begin
               level_words[pri][level_tail[pri]] = word;
               level_tail[pri] = (level_tail[pri] + 1) % LEVEL_DEPTH_DEF;
               level_fill[pri]++;
               add_result('0, STAT_OK, 1'b1, 0);
            end
         end
         OP_GET: begin
            if (visible_words() == 0) add_result('0, STAT_EMPTY, 1'b1, 0);
            else add_result(pop_top(), STAT_OK, 1'b1, 1);
         end
         OP_GET_MANY: begin
            avail = visible_words();
            limit = (want > MAX_WANT_DEF) ? MAX_WANT_DEF : 32'(want);
            n = (limit < avail) ? limit : avail;
            if (avail == 0) begin
               add_result('0, STAT_EMPTY, 1'b1, 0);
            end else if (n == 0) begin
               add_result('0, STAT_OK, 1'b1, 0);
            end else begin
               for (int k = 0; k < n; k++) add_result(pop_top(), STAT_OK, k == n - 1, n);
            end
         end
         default: ;
      endcase
   endfunction

   // all tasks below start and end in the step of a rising clock edge
   task automatic send_item(op_type op, logic [VALUE_W-1:0] word, logic [PRI_W-1:0] pri,
                            logic [WANT_W-1:0] want);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_value        <= word;
      req_priority_req <= pri;
      req_want         <= want;
      do @(posedge clock); while (!req_ready);
      predict_item(op, word, pri, want);
   endtask

   task automatic drain_queue();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic set_levels(logic [CSR_W-1:0] count);
      drain_queue();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      levels_reg = count;
      csr_wr_en <= 1'b0;
   endtask

   function automatic op_type pick_op(int unsigned put_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < put_pct) return OP_PUT;
      if (r < put_pct + (100 - put_pct) / 3) return OP_GET;
      if (r < 96) return OP_GET_MANY;
      return OP_NONE;
   endfunction

   task automatic send_random_items(int unsigned count, int unsigned put_pct);
      int unsigned      sent;
      op_type           op;
      logic [PRI_W-1:0] pri;
      logic [WANT_W-1:0] want;
      sent = 0;
      while (sent < count) begin
         op = pick_op(put_pct);
         if ($urandom_range(0, 4) == 0) pri = PRI_W'($urandom_range(0, LEVELS_DEF - 1));
         else pri = PRI_W'($urandom_range(0, active_levels() - 1));
         if ($urandom_range(0, 9) == 0) want = WANT_W'($urandom_range(0, 31));
         else want = WANT_W'($urandom_range(1, MAX_WANT_DEF));
         send_item(op, $urandom, pri, want);
         if (op != OP_NONE) sent++;
      end
   endtask

   task automatic test_empty_queue();
      send_item(OP_GET, $urandom, 3'd0, 5'd1);
      send_item(OP_GET_MANY, $urandom, 3'd0, 5'd5);
      send_item(OP_NONE, $urandom, PRI_W'($urandom), WANT_W'($urandom));
      send_item(OP_GET_MANY, $urandom, 3'd7, 5'd0);
   endtask

   task automatic test_priority_order();
      send_item(OP_PUT, 32'hFFFF_FFFF, 3'd7, 5'd0);
      send_item(OP_PUT, 32'h0000_0000, 3'd0, 5'd31);
      send_item(OP_PUT, 32'hA5A5_5A5A, 3'd3, 5'd16);
      send_item(OP_PUT, 32'h0000_0001, 3'd0, 5'd1);
      send_item(OP_GET, $urandom, 3'd5, 5'd2);
      // want zero with words waiting
      send_item(OP_GET_MANY, $urandom, 3'd2, 5'd0);
      // want above the maximum
      send_item(OP_GET_MANY, $urandom, 3'd1, 5'd31);
   endtask

   task automatic test_levels_register();
      // zero means one level
      set_levels(4'd0);
      send_item(OP_PUT, 32'h1234_5678, 3'd1, 5'd0);
      send_item(OP_PUT, 32'h0F0F_F0F0, 3'd0, 5'd0);
      send_item(OP_PUT, 32'h5555_AAAA, 3'd5, 5'd0);
      // saturates at eight
      set_levels(4'd15);
      send_item(OP_PUT, 32'hDEAD_0007, 3'd7, 5'd0);
      // level seven stays stored but hidden
      set_levels(4'd2);
      send_item(OP_GET_MANY, $urandom, 3'd0, 5'd16);
      set_levels(4'd8);
      send_item(OP_GET, $urandom, 3'd0, 5'd0);
   endtask

   task automatic test_level_full();
      logic [PRI_W-1:0] lvl;
      lvl = PRI_W'($urandom_range(0, LEVELS_DEF - 1));
      for (int i = 0; i < LEVEL_DEPTH_DEF + 2; i++) begin
         send_item(OP_PUT, $urandom, lvl, WANT_W'($urandom));
      end
      send_item(OP_GET_MANY, $urandom, PRI_W'($urandom), 5'd16);
      send_item(OP_GET_MANY, $urandom, PRI_W'($urandom), 5'd16);
   endtask

   task automatic test_random_mix();
      for (int phase = 0; phase < 7; phase++) begin
         if (phase == 0) set_levels(4'd1);
         else if (phase == 1) set_levels(4'd8);
         else set_levels(CSR_W'($urandom_range(0, 15)));
         send_random_items(30, $urandom_range(45, 80));
      end
   endtask

   task automatic test_backpressure();
      set_levels(4'd8);
      long_hold_pending = 1'b1;
      send_random_items(20, 70);
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      set_levels(CSR_W'($urandom_range(3, 8)));
      send_random_items(70, 55);
   endtask

   // result side: short random stalls, one long hold on request
   initial begin : rsp_side
      int unsigned held;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            rsp_ready <= 1'b0;
            held = 0;
            while (held < LONG_HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      queue_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected item: out_value %0h status %0d last %0b returned_count %0d",
                   rsp_out_value, rsp_status, rsp_last, rsp_returned_count);
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_out_value !== exp_r.out_value) begin
               $error("out_value expected %0h actual %0h", exp_r.out_value, rsp_out_value);
               error_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, rsp_status);
               error_count++;
            end
            if (rsp_last !== exp_r.last) begin
               $error("last expected %0b actual %0b", exp_r.last, rsp_last);
               error_count++;
            end
            if (rsp_returned_count !== exp_r.returned_count) begin
               $error("returned_count expected %0d actual %0d", exp_r.returned_count,
                      rsp_returned_count);
               error_count++;
            end
         end
      end
   end

   initial begin : main_seq
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_priority_order();
      test_levels_register();
      test_level_full();
      test_random_mix();
      test_backpressure();
      test_steady_stream();
      drain_queue();
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("PASS strict_priority_multi_fifo_unit");
      end else begin
         $display("FAIL strict_priority_multi_fifo_unit");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/spmf_pkg.sv
sv/spmf_ram.sv
sv/spmf_levels.sv
sv/strict_priority_multi_fifo_unit.sv
tb/sv/strict_priority_multi_fifo_unit_tb.sv
